// ===== rtl/pngunf_pkg.sv =====
// Shared types, codes and helpers of the PNG scanline unfilter.
package pngunf_pkg;

    localparam int PIXEL_BYTES_W   = 4;
    localparam int ROW_LEN_W       = 14;
    localparam int ROW_BYTES_DEF   = 8192;
    localparam int PIXEL_BYTES_DEF = 8;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [2:0] FILT_NONE  = 3'd0;
    localparam logic [2:0] FILT_SUB   = 3'd1;
    localparam logic [2:0] FILT_UP    = 3'd2;
    localparam logic [2:0] FILT_AVG   = 3'd3;
    localparam logic [2:0] FILT_PAETH = 3'd4;
    localparam logic [7:0] FILT_LAST  = 8'd4;

    localparam logic CFG_PIXEL_BYTES = 1'b0;
    localparam logic CFG_ROW_LENGTH  = 1'b1;

    typedef struct packed {
        logic [PIXEL_BYTES_W-1:0] pixel_bytes;
        logic [ROW_LEN_W-1:0]     row_length;
    } cfg_t;

    typedef struct packed {
        logic       is_err;
        logic [7:0] data;
        logic [2:0] filter;
        logic       first_row;
        logic       has_left;
        logic       last;
    } ent_ctrl_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

    function automatic logic [PIXEL_BYTES_W-1:0] eff_pixel_bytes(
        input logic [PIXEL_BYTES_W-1:0] pb,
        input logic [PIXEL_BYTES_W-1:0] pb_max
    );
        logic [PIXEL_BYTES_W-1:0] v;
        v = pb;
        if (v == '0)
        begin
            v = PIXEL_BYTES_W'(1);
        end
        if (v > pb_max)
        begin
            v = pb_max;
        end
        return v;
    endfunction

endpackage

// ===== rtl/pngunf_front.sv =====
// Front end: accepts stream bytes, tracks row state and queues work for the back end.
module pngunf_front #(
    parameter int MAX_ROW_BYTES   = pngunf_pkg::ROW_BYTES_DEF,
    parameter int MAX_PIXEL_BYTES = pngunf_pkg::PIXEL_BYTES_DEF,
    localparam int COL_W = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     data_valid,
    output logic                     data_ready,
    input  logic [7:0]               data_byte,
    input  logic                     image_start,
    input  pngunf_pkg::cfg_t         cfg,
    input  pngunf_pkg::fifo_status_t fifo_st,
    output logic                     push,
    output pngunf_pkg::ent_ctrl_t    push_ctrl,
    output logic [COL_W-1:0]         push_col
);
    import pngunf_pkg::*;

    localparam int CMP_W = ($clog2(MAX_ROW_BYTES + 1) > ROW_LEN_W) ?
                           $clog2(MAX_ROW_BYTES + 1) : ROW_LEN_W;

    logic [COL_W-1:0] column_count_reg, column_count_next;
    logic [2:0]       row_filter_reg, row_filter_next;
    logic             on_first_row_reg, on_first_row_next;
    logic             await_filter_reg, await_filter_next;
    logic             error_hold_reg, error_hold_next;

    logic                     accept;
    logic                     err_eff;
    logic                     await_eff;
    logic                     first_eff;
    logic [COL_W-1:0]         col_eff;
    logic [PIXEL_BYTES_W-1:0] pb_eff;
    logic [CMP_W-1:0]         rl_eff;
    logic [CMP_W-1:0]         col_ext;
    logic [CMP_W-1:0]         col_inc;
    logic                     last;
    logic                     has_left;

    assign data_ready = !fifo_st.full;
    assign accept     = data_valid && data_ready;

    assign err_eff   = error_hold_reg && !image_start;
    assign await_eff = await_filter_reg || image_start;
    assign first_eff = on_first_row_reg || image_start;
    assign col_eff   = image_start ? '0 : column_count_reg;
    assign pb_eff    = eff_pixel_bytes(cfg.pixel_bytes, PIXEL_BYTES_W'(MAX_PIXEL_BYTES));
    assign col_ext   = CMP_W'(col_eff);
    assign col_inc   = col_ext + CMP_W'(1);
    assign last      = col_inc >= rl_eff;
    assign has_left  = col_ext >= CMP_W'(pb_eff);

    always_comb
    begin
        rl_eff = CMP_W'(cfg.row_length);
        if (rl_eff == '0)
        begin
            rl_eff = CMP_W'(1);
        end
        if (rl_eff > CMP_W'(MAX_ROW_BYTES))
        begin
            rl_eff = CMP_W'(MAX_ROW_BYTES);
        end
    end

    always_comb
    begin
        column_count_next  = column_count_reg;
        row_filter_next    = row_filter_reg;
        on_first_row_next  = on_first_row_reg;
        await_filter_next  = await_filter_reg;
        error_hold_next    = error_hold_reg;
        push               = 1'b0;
        push_ctrl.is_err    = 1'b0;
        push_ctrl.data      = data_byte;
        push_ctrl.filter    = row_filter_reg;
        push_ctrl.first_row = first_eff;
        push_ctrl.has_left  = has_left;
        push_ctrl.last      = last;
        push_col            = col_eff;
        if (accept)
        begin
            if (image_start)
            begin
                on_first_row_next = 1'b1;
                await_filter_next = 1'b1;
                error_hold_next   = 1'b0;
                column_count_next = '0;
            end
            if (err_eff)
            begin
                push = 1'b0;
            end
            else if (await_eff)
            begin
                if (data_byte > FILT_LAST)
                begin
                    error_hold_next  = 1'b1;
                    push             = 1'b1;
                    push_ctrl.is_err = 1'b1;
                end
                else
                begin
                    row_filter_next   = data_byte[2:0];
                    await_filter_next = 1'b0;
                    column_count_next = '0;
                end
            end
            else
            begin
                push = 1'b1;
                if (last)
                begin
                    column_count_next = '0;
                    await_filter_next = 1'b1;
                    on_first_row_next = 1'b0;
                end
                else
                begin
                    column_count_next = COL_W'(col_inc);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            row_filter_reg   <= FILT_NONE;
            on_first_row_reg <= 1'b1;
            await_filter_reg <= 1'b1;
            error_hold_reg   <= 1'b0;
        end
        else
        begin
            column_count_reg <= column_count_next;
            row_filter_reg   <= row_filter_next;
            on_first_row_reg <= on_first_row_next;
            await_filter_reg <= await_filter_next;
            error_hold_reg   <= error_hold_next;
        end
    end

`ifndef ASSERT_OFF
    // A bad filter byte leaves the front waiting for the next image start.
    assert property (@(posedge clk) disable iff (!rst_n)
        error_hold_reg |-> await_filter_reg)
        else $error("error hold set without awaiting a filter byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        await_filter_reg |-> column_count_reg == '0)
        else $error("column count not cleared at a row boundary");

    // Entering error hold must have queued exactly the error beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(error_hold_reg) |-> $past(push && push_ctrl.is_err))
        else $error("error hold entered without an error beat");
`endif

endmodule

// ===== rtl/pngunf_fifo.sv =====
// Short queue that decouples the front end from the back end.
module pngunf_fifo #(
    parameter int WIDTH = 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  logic [WIDTH-1:0]         push_data,
    input  logic                     pop,
    output logic [WIDTH-1:0]         pop_data,
    output pngunf_pkg::fifo_status_t status
);
    import pngunf_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign status.full  = count_reg == CNT_W'(QUEUE_DEPTH);
    assign status.empty = count_reg == '0;
    assign pop_data     = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                          wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                          rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef ASSERT_OFF
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !status.full)
        else $error("queue written while full");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("queue read while empty");

    assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("queue count did not follow a lone write");
`endif

endmodule

// ===== rtl/pngunf_back.sv =====
// Back end: line store read, byte reconstruction and the output register.
module pngunf_back #(
    parameter int MAX_ROW_BYTES   = pngunf_pkg::ROW_BYTES_DEF,
    parameter int MAX_PIXEL_BYTES = pngunf_pkg::PIXEL_BYTES_DEF,
    localparam int COL_W = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  pngunf_pkg::cfg_t         cfg,
    input  pngunf_pkg::fifo_status_t fifo_st,
    output logic                     pop,
    input  pngunf_pkg::ent_ctrl_t    pop_ctrl,
    input  logic [COL_W-1:0]         pop_col,
    output logic                     pixel_valid,
    input  logic                     pixel_ready,
    output logic [7:0]               pixel_byte,
    output logic                     row_end,
    output logic                     bad_filter
);
    import pngunf_pkg::*;

    localparam int IDX_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

    logic [7:0]       line_mem [MAX_ROW_BYTES];
    logic [7:0]       line_q_reg;
    logic             s1_valid_reg;
    ent_ctrl_t        s1_ctrl_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic             byp_hit_reg;
    logic [7:0]       byp_data_reg;
    logic [7:0]       left_hist_reg [MAX_PIXEL_BYTES];
    logic [7:0]       ul_hist_reg [MAX_PIXEL_BYTES];
    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic             out_end_reg;
    logic             out_bad_reg;

    logic                     s1_fire;
    logic                     wr_en;
    logic [PIXEL_BYTES_W-1:0] pb_eff;
    logic [IDX_W-1:0]         idx;
    logic [7:0]               above_raw;
    logic [7:0]               a;
    logic [7:0]               b;
    logic [7:0]               c;
    logic signed [8:0]        d_ac;
    logic signed [8:0]        d_bc;
    logic signed [9:0]        d_sum;
    logic [9:0]               pa;
    logic [9:0]               pb_dist;
    logic [9:0]               pc;
    logic [7:0]               paeth;
    logic [8:0]               avg_sum;
    logic [7:0]               pred;
    logic [7:0]               recon;

    assign s1_fire = s1_valid_reg && (!out_valid_reg || pixel_ready);
    assign pop     = !fifo_st.empty && (!s1_valid_reg || s1_fire);
    assign wr_en   = s1_fire && !s1_ctrl_reg.is_err;

    assign pb_eff = eff_pixel_bytes(cfg.pixel_bytes, PIXEL_BYTES_W'(MAX_PIXEL_BYTES));
    assign idx    = IDX_W'(pb_eff - PIXEL_BYTES_W'(1));

    assign above_raw = byp_hit_reg ? byp_data_reg : line_q_reg;
    assign b = s1_ctrl_reg.first_row ? 8'd0 : above_raw;
    assign a = s1_ctrl_reg.has_left ? left_hist_reg[idx] : 8'd0;
    assign c = (!s1_ctrl_reg.first_row && s1_ctrl_reg.has_left) ? ul_hist_reg[idx] : 8'd0;

    // With p = a + b - c, the three distances reduce to |b-c|, |a-c| and |a+b-2c|.
    assign d_ac  = $signed({1'b0, a}) - $signed({1'b0, c});
    assign d_bc  = $signed({1'b0, b}) - $signed({1'b0, c});
    assign d_sum = 10'(d_ac) + 10'(d_bc);
    assign pa      = d_bc[8] ? 10'(-d_bc) : 10'(d_bc);
    assign pb_dist = d_ac[8] ? 10'(-d_ac) : 10'(d_ac);
    assign pc      = d_sum[9] ? 10'(-d_sum) : 10'(d_sum);

    always_comb
    begin
        if (pa <= pb_dist && pa <= pc)
        begin
            paeth = a;
        end
        else if (pb_dist <= pc)
        begin
            paeth = b;
        end
        else
        begin
            paeth = c;
        end
    end

    assign avg_sum = {1'b0, a} + {1'b0, b};

    always_comb
    begin
        case (s1_ctrl_reg.filter)
            FILT_SUB:   pred = a;
            FILT_UP:    pred = b;
            FILT_AVG:   pred = avg_sum[8:1];
            FILT_PAETH: pred = paeth;
            default:    pred = 8'd0;
        endcase
    end

    assign recon = s1_ctrl_reg.data + pred;

    // The read port returns old data on a same-address write, so that case is bypassed.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_mem[s1_col_reg] <= recon;
        end
        if (pop)
        begin
            line_q_reg <= line_mem[pop_col];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_ctrl_reg  <= pop_ctrl;
            s1_col_reg   <= pop_col;
            byp_data_reg <= recon;
        end
        if (s1_fire)
        begin
            out_byte_reg <= s1_ctrl_reg.is_err ? 8'd0 : recon;
            out_end_reg  <= s1_ctrl_reg.is_err ? 1'b0 : s1_ctrl_reg.last;
            out_bad_reg  <= s1_ctrl_reg.is_err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            byp_hit_reg   <= 1'b0;
            for (int i = 0; i < MAX_PIXEL_BYTES; i++)
            begin
                left_hist_reg[i] <= 8'd0;
                ul_hist_reg[i]   <= 8'd0;
            end
        end
        else
        begin
            if (pop)
            begin
                s1_valid_reg <= 1'b1;
                byp_hit_reg  <= wr_en && (s1_col_reg == pop_col);
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pixel_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (wr_en)
            begin
                for (int i = MAX_PIXEL_BYTES - 1; i > 0; i--)
                begin
                    left_hist_reg[i] <= left_hist_reg[i-1];
                    ul_hist_reg[i]   <= ul_hist_reg[i-1];
                end
                left_hist_reg[0] <= recon;
                ul_hist_reg[0]   <= b;
            end
        end
    end

    assign pixel_valid = out_valid_reg;
    assign pixel_byte  = out_byte_reg;
    assign row_end     = out_end_reg;
    assign bad_filter  = out_bad_reg;

`ifndef ASSERT_OFF
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_bad_reg |-> out_byte_reg == 8'd0 && !out_end_reg)
        else $error("error beat carries pixel data or a row end");

    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && !pixel_ready |=> s1_valid_reg)
        else $error("execute stage dropped a beat under back pressure");

    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_fire |=> $stable(s1_col_reg) && $stable(s1_ctrl_reg))
        else $error("stalled execute stage changed its beat");
`endif

endmodule

// ===== rtl/png_scanline_unfilter_top.sv =====
// Top level of the PNG scanline unfilter: configuration registers, front, queue and back.
//
// The input channel (data_valid/data_ready) takes the inflated stream one byte per beat;
// image_start marks the filter byte that opens a new image. The output channel
// (pixel_valid/pixel_ready) returns one beat per row byte with the reconstructed byte and
// row_end on the last byte of each scanline, or a single bad_filter beat when a filter
// byte exceeds four; after that, bytes are dropped until the next image start.
// Filter bytes produce no output beat.
// Throughput is one byte per cycle while the receiver is ready. A row byte passes from the
// four-entry queue, with its line-store read, into the execute stage, where the left-neighbor
// recurrence and the Paeth selection are combinational, and then into the output register.
// When the receiver stalls, the output register holds its beat, the execute stage holds,
// and the queue fills; data_ready falls only when the queue is full.
// The config channel writes pixel_bytes (index 0) or row_length (index 1) and is always
// ready; write it only while the block is idle. Reset sets both registers to one and
// starts at row zero awaiting a filter byte. The line store needs no clearing after reset.
module png_scanline_unfilter_top #(
    parameter int MAX_ROW_BYTES   = pngunf_pkg::ROW_BYTES_DEF,
    parameter int MAX_PIXEL_BYTES = pngunf_pkg::PIXEL_BYTES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              data_valid,
    output logic                              data_ready,
    input  logic [7:0]                        data_byte,
    input  logic                              image_start,
    output logic                              pixel_valid,
    input  logic                              pixel_ready,
    output logic [7:0]                        pixel_byte,
    output logic                              row_end,
    output logic                              bad_filter,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_index,
    input  logic [pngunf_pkg::ROW_LEN_W-1:0]  cfg_data
);
    import pngunf_pkg::*;

    localparam int COL_W   = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int ENTRY_W = $bits(ent_ctrl_t) + COL_W;

    cfg_t         cfg_reg;
    fifo_status_t fifo_st;
    logic         push;
    ent_ctrl_t    push_ctrl;
    logic [COL_W-1:0] push_col;
    logic         pop;
    ent_ctrl_t    pop_ctrl;
    logic [COL_W-1:0] pop_col;
    logic [ENTRY_W-1:0] push_data;
    logic [ENTRY_W-1:0] pop_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pixel_bytes <= PIXEL_BYTES_W'(1);
            cfg_reg.row_length  <= ROW_LEN_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_PIXEL_BYTES: cfg_reg.pixel_bytes <= cfg_data[PIXEL_BYTES_W-1:0];
                CFG_ROW_LENGTH:  cfg_reg.row_length  <= cfg_data;
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    pngunf_front #(
        .MAX_ROW_BYTES   (MAX_ROW_BYTES),
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_valid  (data_valid),
        .data_ready  (data_ready),
        .data_byte   (data_byte),
        .image_start (image_start),
        .cfg         (cfg_reg),
        .fifo_st     (fifo_st),
        .push        (push),
        .push_ctrl   (push_ctrl),
        .push_col    (push_col)
    );

    assign push_data = {push_ctrl, push_col};
    assign pop_ctrl  = pop_data[ENTRY_W-1:COL_W];
    assign pop_col   = pop_data[COL_W-1:0];

    pngunf_fifo #(
        .WIDTH (ENTRY_W)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (fifo_st)
    );

    pngunf_back #(
        .MAX_ROW_BYTES   (MAX_ROW_BYTES),
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .fifo_st     (fifo_st),
        .pop         (pop),
        .pop_ctrl    (pop_ctrl),
        .pop_col     (pop_col),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel_byte  (pixel_byte),
        .row_end     (row_end),
        .bad_filter  (bad_filter)
    );

endmodule
